>>> src/clt_pkg.sv
// Shared types, byte codes and event codes for the command line tokenizer.
// Depends on nothing; the decode, result register, top level and bench refer to it by scoped names.
package clt_pkg;

   // Most results one input word can produce
   localparam int MaxRes = 3;

   // Byte codes with a meaning of their own
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_PIPE      = 8'h7C;
   localparam logic [7:0] CH_DQUOTE    = 8'h22;
   localparam logic [7:0] CH_SQUOTE    = 8'h27;
   localparam logic [7:0] CH_SPACE     = 8'h20;
   localparam logic [7:0] CH_TAB       = 8'h09;
   localparam logic [7:0] CH_CR        = 8'h0D;

   // Event codes on the result channel
   localparam logic [2:0] EV_BYTE      = 3'd0;
   localparam logic [2:0] EV_WORD_END  = 3'd1;
   localparam logic [2:0] EV_PIPE      = 3'd2;
   localparam logic [2:0] EV_LINE_DONE = 3'd3;
   localparam logic [2:0] EV_QUOTE_ERR = 3'd4;

   // Quote modes
   localparam logic [1:0] QM_NONE   = 2'd0;
   localparam logic [1:0] QM_SINGLE = 2'd1;
   localparam logic [1:0] QM_DOUBLE = 2'd2;

   typedef struct packed {
      logic [1:0] quote_mode;
      logic       in_word;
      logic       escape_pending;
   } state_type;

   typedef struct packed {
      logic [2:0] event_res;
      logic [7:0] word_byte;
   } res_type;

   // Everything one input word produces
   typedef struct packed {
      logic [1:0]               cnt;
      res_type [MaxRes-1:0]     res;
      state_type                next_state;
   } dec_type;

endpackage

>>> src/clt_if.sv
// Valid/ready channel interfaces for the request and response words.
// Depends on nothing.
interface clt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] ch;
   logic       line_end;

   modport source (output valid, output ch, output line_end, input ready);
   modport sink   (input valid, input ch, input line_end, output ready);
endinterface

interface clt_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] event_res;
   logic [7:0] word_byte;
   logic       last;

   modport source (output valid, output event_res, output word_byte, output last, input ready);
   modport sink   (input valid, input event_res, input word_byte, input last, output ready);
endinterface

>>> src/clt_decode.sv
// Per-byte decode: turns one byte plus tokenizer state into up to three
// results and the next state. Uses clt_pkg.
module clt_decode (
   input  logic [7:0]          ch,
   input  logic                line_end,
   input  clt_pkg::state_type  state,
   output clt_pkg::dec_type    dec
);

   always_comb begin
      logic [1:0]         n;
      logic [7:0]         closer;
      logic               is_space;
      clt_pkg::state_type st;

      n        = 2'd0;
      st       = state;
      is_space = (ch == clt_pkg::CH_SPACE) ||
                 ((ch >= clt_pkg::CH_TAB) && (ch <= clt_pkg::CH_CR));
      closer   = (state.quote_mode == clt_pkg::QM_SINGLE) ? clt_pkg::CH_SQUOTE
                                                          : clt_pkg::CH_DQUOTE;
      dec      = '0;

      // Classify the byte against the current state
      if (state.escape_pending) begin
         st.escape_pending = 1'b0;
         dec.res[n] = '{clt_pkg::EV_BYTE, ch};
         n = n + 2'd1;
         st.in_word = 1'b1;
      end else if (ch == clt_pkg::CH_BACKSLASH) begin
         st.escape_pending = 1'b1;
      end else if (state.quote_mode != clt_pkg::QM_NONE) begin
         if (ch == closer) begin
            dec.res[n] = '{clt_pkg::EV_WORD_END, 8'h00};
            n = n + 2'd1;
            st.quote_mode = clt_pkg::QM_NONE;
            st.in_word = 1'b0;
         end else begin
            dec.res[n] = '{clt_pkg::EV_BYTE, ch};
            n = n + 2'd1;
         end
      end else if (is_space) begin
         if (state.in_word) begin
            dec.res[n] = '{clt_pkg::EV_WORD_END, 8'h00};
            n = n + 2'd1;
         end
         st.in_word = 1'b0;
      end else if (ch == clt_pkg::CH_PIPE) begin
         if (state.in_word) begin
            dec.res[n] = '{clt_pkg::EV_WORD_END, 8'h00};
            n = n + 2'd1;
         end
         dec.res[n] = '{clt_pkg::EV_PIPE, 8'h00};
         n = n + 2'd1;
         st.in_word = 1'b0;
      end else if ((ch == clt_pkg::CH_SQUOTE) || (ch == clt_pkg::CH_DQUOTE)) begin
         if (state.in_word) begin
            dec.res[n] = '{clt_pkg::EV_WORD_END, 8'h00};
            n = n + 2'd1;
         end
         st.quote_mode = (ch == clt_pkg::CH_SQUOTE) ? clt_pkg::QM_SINGLE
                                                    : clt_pkg::QM_DOUBLE;
         st.in_word = 1'b1;
      end else begin
         dec.res[n] = '{clt_pkg::EV_BYTE, ch};
         n = n + 2'd1;
         st.in_word = 1'b1;
      end

      // Close the line on the final byte
      if (line_end) begin
         if (st.quote_mode != clt_pkg::QM_NONE) begin
            dec.res[n] = '{clt_pkg::EV_QUOTE_ERR, 8'h00};
            n = n + 2'd1;
         end else begin
            if (st.in_word) begin
               dec.res[n] = '{clt_pkg::EV_WORD_END, 8'h00};
               n = n + 2'd1;
            end
            dec.res[n] = '{clt_pkg::EV_LINE_DONE, 8'h00};
            n = n + 2'd1;
         end
         st = '0;
      end

      dec.cnt        = n;
      dec.next_state = st;
   end

endmodule

>>> src/clt_rsp_buf.sv
// Result register: holds the results of one byte and hands them out one
// word at a time. Uses clt_pkg and clt_rsp_if.
module clt_rsp_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  clt_pkg::dec_type    dec,
   output logic                buf_free,
   clt_rsp_if.source           rsp_chan
);

   logic [1:0]       cnt_ff, cnt_in;
   logic [1:0]       idx_ff, idx_in;
   clt_pkg::res_type res_ff [clt_pkg::MaxRes];
   clt_pkg::res_type cur;
   logic             take;

   assign rsp_chan.valid = (idx_ff != cnt_ff);
   assign take           = rsp_chan.valid && rsp_chan.ready;

   // Free when empty or the last held word leaves now
   assign buf_free = (idx_ff == cnt_ff) || (take && ((idx_ff + 2'd1) == cnt_ff));

   // Select the word at the read index
   always_comb begin
      unique case (idx_ff)
         2'd0:    cur = res_ff[0];
         2'd1:    cur = res_ff[1];
         2'd2:    cur = res_ff[2];
         default: cur = '0;
      endcase
   end

   assign rsp_chan.event_res = cur.event_res;
   assign rsp_chan.word_byte = cur.word_byte;
   assign rsp_chan.last      = ((idx_ff + 2'd1) == cnt_ff);

   // Load a new set or advance the read index
   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (load) begin
         cnt_in = dec.cnt;
         idx_in = 2'd0;
      end else if (take) begin
         idx_in = idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         idx_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         idx_ff <= idx_in;
      end
   end

   // Hold result payload
   always_ff @(posedge clock) begin
      if (load) begin
         res_ff[0] <= dec.res[0];
         res_ff[1] <= dec.res[1];
         res_ff[2] <= dec.res[2];
      end
   end

endmodule

>>> src/command_line_tokenizer.sv
// Command line tokenizer, top level. An accepted byte passes the input register,
// then the result register, which shows its first result; a full result register stalls it.
// Throughput: one byte per cycle while each byte gives at most one result and the
// receiver takes every result; a byte with more results holds the result register until all are taken.
// Reset (synchronous, active high) empties both registers and clears the
// quote, word and escape state. Uses clt_pkg, clt_if, clt_decode, clt_rsp_buf.
module command_line_tokenizer (
   input  logic       clock,
   input  logic       reset,
   clt_req_if.sink    req_chan,
   clt_rsp_if.source  rsp_chan
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         ch_ff;
   logic               line_end_ff;
   clt_pkg::state_type state_ff, state_in;
   clt_pkg::dec_type   dec;
   logic               buf_free;
   logic               load;
   logic               req_take;

   // Move the held byte into the result register when it frees up
   assign load           = in_valid_ff && buf_free;
   assign req_chan.ready = !in_valid_ff || load;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign in_valid_in = req_take || (in_valid_ff && !load);
   assign state_in    = load ? dec.next_state : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         state_ff    <= '0;
      end else begin
         in_valid_ff <= in_valid_in;
         state_ff    <= state_in;
      end
   end

   // Hold the input word
   always_ff @(posedge clock) begin
      if (req_take) begin
         ch_ff       <= req_chan.ch;
         line_end_ff <= req_chan.line_end;
      end
   end

   clt_decode u_decode (
      .ch       (ch_ff),
      .line_end (line_end_ff),
      .state    (state_ff),
      .dec      (dec)
   );

   clt_rsp_buf u_rsp_buf (
      .clock    (clock),
      .reset    (reset),
      .load     (load),
      .dec      (dec),
      .buf_free (buf_free),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> verif/tb.sv
// Self-checking bench for command_line_tokenizer: directed and random command lines in,
// each result word checked against a cycle-free token predictor.
// Depends on clt_pkg, clt_if and the RTL under src.
`timescale 1ns / 1ps

module tb;

   localparam int LimitCycles = 200_000;
   localparam int HalfPeriod  = 4;

   typedef struct {
      logic [7:0] ch;
      logic       line_end;
      bit         drain_first;  // wait for every result before offering this byte
   } line_byte_type;

   typedef struct {
      logic [2:0] event_res;
      logic [7:0] word_byte;
      logic       last;
   } token_type;

   logic clock;
   logic reset;

   clt_req_if req_chan ();
   clt_rsp_if rsp_chan ();

   command_line_tokenizer dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   line_byte_type pending_bytes[$];
   token_type     expected_tokens[$];
   logic [7:0]    line_buf[$];

   // Predictor state
   logic [1:0] quote_state = clt_pkg::QM_NONE;
   logic       word_open   = 1'b0;
   logic       escape_open = 1'b0;

   int  mismatches  = 0;
   int  bytes_sent  = 0;
   int  tokens_seen = 0;
   int  hold_left   = 0;
   bit  hold_done   = 1'b0;
   bit  offer;

   always #HalfPeriod clock = ~clock;

   function automatic bit is_blank(input logic [7:0] c);
      return c == clt_pkg::CH_SPACE || (c >= clt_pkg::CH_TAB && c <= clt_pkg::CH_CR);
   endfunction

   // Work out the tokens one accepted byte gives and queue them
   function automatic void tokenize_byte(input logic [7:0] c, input logic fin);
      token_type  found[$];
      logic [7:0] closer;
      if (escape_open) begin
         escape_open = 1'b0;
         found.push_back('{clt_pkg::EV_BYTE, c, 1'b0});
         word_open = 1'b1;
      end else if (c == clt_pkg::CH_BACKSLASH) begin
         escape_open = 1'b1;
      end else if (quote_state != clt_pkg::QM_NONE) begin
         closer = (quote_state == clt_pkg::QM_SINGLE) ? clt_pkg::CH_SQUOTE
                                                      : clt_pkg::CH_DQUOTE;
         if (c == closer) begin
            found.push_back('{clt_pkg::EV_WORD_END, 8'h00, 1'b0});
            quote_state = clt_pkg::QM_NONE;
            word_open   = 1'b0;
         end else begin
            found.push_back('{clt_pkg::EV_BYTE, c, 1'b0});
         end
      end else if (is_blank(c)) begin
         if (word_open) found.push_back('{clt_pkg::EV_WORD_END, 8'h00, 1'b0});
         word_open = 1'b0;
      end else if (c == clt_pkg::CH_PIPE) begin
         if (word_open) found.push_back('{clt_pkg::EV_WORD_END, 8'h00, 1'b0});
         found.push_back('{clt_pkg::EV_PIPE, 8'h00, 1'b0});
         word_open = 1'b0;
      end else if (c == clt_pkg::CH_SQUOTE || c == clt_pkg::CH_DQUOTE) begin
         if (word_open) found.push_back('{clt_pkg::EV_WORD_END, 8'h00, 1'b0});
         quote_state = (c == clt_pkg::CH_SQUOTE) ? clt_pkg::QM_SINGLE : clt_pkg::QM_DOUBLE;
         word_open   = 1'b1;
      end else begin
         found.push_back('{clt_pkg::EV_BYTE, c, 1'b0});
         word_open = 1'b1;
      end

      // Close the line: error if a quote is still open
      if (fin) begin
         if (quote_state != clt_pkg::QM_NONE) begin
            found.push_back('{clt_pkg::EV_QUOTE_ERR, 8'h00, 1'b0});
         end else begin
            if (word_open) found.push_back('{clt_pkg::EV_WORD_END, 8'h00, 1'b0});
            found.push_back('{clt_pkg::EV_LINE_DONE, 8'h00, 1'b0});
         end
         quote_state = clt_pkg::QM_NONE;
         word_open   = 1'b0;
         escape_open = 1'b0;
      end

      if (found.size() != 0) found[found.size()-1].last = 1'b1;
      foreach (found[i]) expected_tokens.push_back(found[i]);
   endfunction

   task automatic report_mismatch(input string what, input token_type got,
                                  input token_type want);
      $display("%0t: %s: got ev %0d byte %02h last %0b, want ev %0d byte %02h last %0b",
               $realtime, what, got.event_res, got.word_byte, got.last,
               want.event_res, want.word_byte, want.last);
      mismatches++;
   endtask

   // Request driver: predict on acceptance, then offer the next byte or idle
   always @(posedge clock) begin
      if (reset) begin
         req_chan.valid <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            tokenize_byte(req_chan.ch, req_chan.line_end);
            void'(pending_bytes.pop_front());
            bytes_sent++;
         end
         if (!req_chan.valid || req_chan.ready) begin
            offer = pending_bytes.size() != 0;
            if (offer && pending_bytes[0].drain_first && expected_tokens.size() != 0)
               offer = 1'b0;
            // no gaps while the middle of the run streams through
            if (offer && !(bytes_sent >= 150 && bytes_sent < 260) && $urandom_range(99) < 32)
               offer = 1'b0;
            if (offer) begin
               req_chan.valid    <= 1'b1;
               req_chan.ch       <= pending_bytes[0].ch;
               req_chan.line_end <= pending_bytes[0].line_end;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // Hold off the receiver once for a long stretch so the block backs up
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (tokens_seen >= 80 && !hold_done) begin
         hold_left <= 300;
         hold_done <= 1'b1;
      end
   end

   // Result monitor: check each accepted word, then choose ready
   always @(posedge clock) begin
      token_type got;
      token_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.event_res, rsp_chan.word_byte, rsp_chan.last};
            tokens_seen++;
            if (expected_tokens.size() == 0) begin
               report_mismatch("unexpected word", got, '{clt_pkg::EV_BYTE, 8'h00, 1'b0});
            end else begin
               want = expected_tokens.pop_front();
               if (got.event_res !== want.event_res)
                  report_mismatch("event_res", got, want);
               else if (got.word_byte !== want.word_byte)
                  report_mismatch("word_byte", got, want);
               else if (got.last !== want.last)
                  report_mismatch("last", got, want);
            end
         end
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= (tokens_seen >= 300 && tokens_seen < 500) ||
                              $urandom_range(99) >= 32;
         end
      end
   end

   function automatic logic [7:0] plain_byte();
      logic [7:0] c;
      c = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8'h21, 8'h7E));
      while (c == clt_pkg::CH_BACKSLASH || c == clt_pkg::CH_PIPE ||
             c == clt_pkg::CH_DQUOTE || c == clt_pkg::CH_SQUOTE || is_blank(c))
         c = 8'($urandom_range(8'h41, 8'h5A));
      return c;
   endfunction

   function automatic logic [7:0] blank_byte();
      return ($urandom_range(1) == 0) ? clt_pkg::CH_SPACE
                                      : 8'($urandom_range(clt_pkg::CH_TAB, clt_pkg::CH_CR));
   endfunction

   function automatic logic [7:0] noise_byte();
      case ($urandom_range(5))
         0:       return clt_pkg::CH_BACKSLASH;
         1:       return clt_pkg::CH_PIPE;
         2:       return ($urandom_range(1) == 0) ? clt_pkg::CH_SQUOTE : clt_pkg::CH_DQUOTE;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Fill line_buf with one random line, mostly well formed
   function automatic void make_line();
      logic [7:0] q;
      line_buf.delete();
      if ($urandom_range(99) < 12) begin
         repeat ($urandom_range(1, 10)) line_buf.push_back(noise_byte());
      end else begin
         repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(7))
               0, 1, 7: repeat ($urandom_range(1, 4)) line_buf.push_back(plain_byte());
               2, 6:    repeat ($urandom_range(1, 2)) line_buf.push_back(blank_byte());
               3:       line_buf.push_back(clt_pkg::CH_PIPE);
               4: begin
                  q = ($urandom_range(1) == 0) ? clt_pkg::CH_SQUOTE : clt_pkg::CH_DQUOTE;
                  line_buf.push_back(q);
                  repeat ($urandom_range(0, 3)) begin
                     case ($urandom_range(4))
                        0: begin
                           line_buf.push_back(clt_pkg::CH_BACKSLASH);
                           line_buf.push_back(8'($urandom_range(255)));
                        end
                        1: line_buf.push_back(blank_byte());
                        2: line_buf.push_back(q == clt_pkg::CH_SQUOTE ? clt_pkg::CH_DQUOTE
                                                                      : clt_pkg::CH_SQUOTE);
                        3: line_buf.push_back(clt_pkg::CH_PIPE);
                        default: line_buf.push_back(plain_byte());
                     endcase
                  end
                  line_buf.push_back(q);
               end
               5: begin
                  line_buf.push_back(clt_pkg::CH_BACKSLASH);
                  line_buf.push_back(8'($urandom_range(255)));
               end
               default: ;
            endcase
         end
      end
   endfunction

   function automatic void queue_line(input bit drain);
      foreach (line_buf[i])
         pending_bytes.push_back('{line_buf[i], i == line_buf.size() - 1, drain && i == 0});
   endfunction

   // Stimulus and end of run
   initial begin
      int lines;
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid    = 1'b0;
      req_chan.ch       = 8'h00;
      req_chan.line_end = 1'b0;
      rsp_chan.ready    = 1'b0;

      // Blank and pipe before any word, quotes against words, empty quoted word,
      // escapes outside a word and doubled, zero and 0xFF bytes, escaped quote inside
      line_buf = '{clt_pkg::CH_SPACE, clt_pkg::CH_PIPE, 8'h61, clt_pkg::CH_DQUOTE,
                   clt_pkg::CH_DQUOTE, 8'h62, clt_pkg::CH_BACKSLASH, clt_pkg::CH_BACKSLASH,
                   clt_pkg::CH_TAB, clt_pkg::CH_BACKSLASH, clt_pkg::CH_SPACE, 8'h00,
                   clt_pkg::CH_PIPE, clt_pkg::CH_SQUOTE, clt_pkg::CH_BACKSLASH,
                   clt_pkg::CH_SQUOTE, clt_pkg::CH_DQUOTE, clt_pkg::CH_SQUOTE, 8'hFF};
      queue_line(1'b0);
      // Open double quote at line end, after a full drain
      line_buf = '{clt_pkg::CH_DQUOTE, 8'h78};
      queue_line(1'b1);
      // Backslash as the final byte
      line_buf = '{8'h71, clt_pkg::CH_BACKSLASH};
      queue_line(1'b0);
      // Lone blank line
      line_buf = '{8'h0B};
      queue_line(1'b0);
      // Word, then pipe on the final byte
      line_buf = '{8'h7A, clt_pkg::CH_PIPE};
      queue_line(1'b0);
      // Lone open single quote
      line_buf = '{clt_pkg::CH_SQUOTE};
      queue_line(1'b0);

      lines = 0;
      while (pending_bytes.size() < 420) begin
         make_line();
         queue_line(lines % 25 == 24);
         lines++;
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || expected_tokens.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #(LimitCycles * 2 * HalfPeriod);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
